// File: hw/rtl/rpn_pkg.sv
// rpn_pkg: shared types, operation and status codes for the rpn stack calculator
// no dependencies

package rpn_pkg;

  localparam int STACK_DEPTH_DEF = 128;
  localparam int DATA_W = 32;
  localparam int DEPTH_W = 8;

  typedef enum logic [3:0] {
    OP_PUSH  = 4'd0,
    OP_ADD   = 4'd1,
    OP_SUB   = 4'd2,
    OP_MUL   = 4'd3,
    OP_DIV   = 4'd4,
    OP_PEEK  = 4'd5,
    OP_SWAP  = 4'd6,
    OP_CLEAR = 4'd7,
    OP_DUP   = 4'd8,
    OP_POP   = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_ZDIV    = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               has_value;
    logic [2:0]         status;
    logic [7:0]         depth;
  } out_item_t;

endpackage

// File: hw/rtl/rpn_stack_calculator.sv
// rpn_stack_calculator: operand stack calculator on signed q16.16 values
// depends on rpn_pkg
//
//   channel | dir | type       | handshake
//   in      | in  | in_item_t  | in_valid / in_ready
//   out     | out | out_item_t | out_valid / out_ready
//
// one item at a time; one result beat per item. every item first reads the top entry;
// peek, clear, pop and unknown then finish, push and dup then write, and
// add/sub/swap read a second entry over the single registered read port, then write.
// mul: 32 serial add-shift steps, one multiplier bit a cycle.
// div: 48 restoring steps on magnitudes, one quotient bit a cycle.
// the next beat can be taken in the cycle after the result is registered.
// reset clears the count and the control; the stack memory is not cleared.
// a result still waiting in the output register holds the sequencer in its
// last state until taken.

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  rpn_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rpn_pkg::out_item_t  out_data
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_RD_B  = 10'b0000000010,
    S_RD_A  = 10'b0000000100,
    S_WAIT  = 10'b0000001000,
    S_MUL   = 10'b0000010000,
    S_DIV   = 10'b0000100000,
    S_WR1   = 10'b0001000000,
    S_WR2   = 10'b0010000000,
    S_DONE  = 10'b0100000000,
    S_FIX   = 10'b1000000000
  } state_t;

  state_t state;

  // stack storage, one write and one registered read port
  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  logic [31:0]   wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  logic [3:0]  op;
  logic [31:0] value;
  logic [CW-1:0] cnt;       // committed count
  logic [CW-1:0] wcnt;      // working count during an item
  logic [2:0]  status;
  logic [31:0] opb, opa;    // b popped first, then a
  logic [31:0] res1, res2;  // values to push
  logic [1:0]  npush;
  logic [31:0] result;
  logic        has;
  logic        obusy;

  // serial arithmetic registers
  logic [63:0] acc;
  logic [31:0] mplier;
  logic [5:0]  step;
  logic [47:0] dquo;        // dividend magnitude shifting into the quotient
  logic [32:0] drem;
  logic [31:0] dvs;
  logic        neg;

  logic [32:0] rem_try;
  logic [47:0] qmag;
  logic signed [49:0] qs;
  logic signed [63:0] prod_s;
  logic signed [47:0] sh;
  logic [31:0] sat_mul, sat_div;

  assign rem_try = {drem[31:0], dquo[47]} - {1'b0, dvs};

  // mul: floor shift then saturate
  always_comb begin
    prod_s = acc;
    sh = prod_s[63:16];
    if (sh > 48'sh7FFFFFFF) sat_mul = 32'h7FFFFFFF;
    else if (sh < -48'sh80000000) sat_mul = 32'h80000000;
    else sat_mul = sh[31:0];
  end

  // div: sign the magnitude quotient and saturate
  always_comb begin
    qmag = dquo;
    qs = neg ? -$signed({2'b00, qmag}) : $signed({2'b00, qmag});
    if (qs > 50'sh7FFFFFFF) sat_div = 32'h7FFFFFFF;
    else if (qs < -50'sh80000000) sat_div = 32'h80000000;
    else sat_div = qs[31:0];
  end

  function automatic logic [2:0] first_err(logic [2:0] cur, logic [2:0] code);
    return (cur == rpn_pkg::ST_OK) ? code : cur;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign out_valid = obusy;

  logic is_bin;
  assign is_bin = (op == rpn_pkg::OP_ADD) || (op == rpn_pkg::OP_SUB) ||
                  (op == rpn_pkg::OP_MUL) || (op == rpn_pkg::OP_DIV) ||
                  (op == rpn_pkg::OP_SWAP);

  always_comb begin
    wr_en = 1'b0;
    wr_addr = wcnt[AW-1:0];
    wr_data = res1;
    rd_addr = (wcnt == '0) ? '0 : AW'(wcnt - CW'(1));
    if (state == S_WR1) begin
      wr_en = (wcnt < CW'(STACK_DEPTH)) && (npush != 2'd0);
      wr_data = res1;
    end else if (state == S_WR2) begin
      wr_en = (wcnt < CW'(STACK_DEPTH));
      wr_data = res2;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      wcnt <= '0;
      obusy <= 1'b0;
    end else begin
      // output register: loaded from the done state, emptied when taken
      if (state == S_DONE && (!obusy || out_ready)) obusy <= 1'b1;
      else if (out_ready) obusy <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op <= in_data.op;
            value <= in_data.value;
            wcnt <= cnt;
            status <= rpn_pkg::ST_OK;
            result <= '0;
            has <= 1'b0;
            npush <= 2'd0;
            state <= S_RD_B;
          end
        end
        S_RD_B: begin
          // first read issued in this cycle from rd_addr = top
          state <= S_FIX;
        end
        S_FIX: begin
          // rd_data now holds top entry
          case (op)
            rpn_pkg::OP_PUSH: begin
              res1 <= value;
              npush <= 2'd1;
              state <= S_WR1;
            end
            rpn_pkg::OP_PEEK: begin
              if (wcnt != '0) begin
                result <= rd_data;
                has <= 1'b1;
              end else begin
                status <= rpn_pkg::ST_EMPTY;
              end
              state <= S_DONE;
            end
            rpn_pkg::OP_CLEAR: begin
              wcnt <= '0;
              state <= S_DONE;
            end
            rpn_pkg::OP_POP: begin
              if (wcnt != '0) begin
                result <= rd_data;
                has <= 1'b1;
                wcnt <= wcnt - CW'(1);
              end else begin
                status <= rpn_pkg::ST_EMPTY;
              end
              state <= S_DONE;
            end
            rpn_pkg::OP_DUP: begin
              if (wcnt != '0) begin
                res1 <= rd_data;
                res2 <= rd_data;
                wcnt <= wcnt - CW'(1);
              end else begin
                res1 <= '0;
                res2 <= '0;
                status <= rpn_pkg::ST_EMPTY;
              end
              npush <= 2'd2;
              state <= S_WR1;
            end
            default: begin
              if (is_bin) begin
                if (wcnt != '0) begin
                  opb <= rd_data;
                  wcnt <= wcnt - CW'(1);
                end else begin
                  opb <= '0;
                  status <= rpn_pkg::ST_EMPTY;
                end
                state <= S_RD_A;
              end else begin
                status <= rpn_pkg::ST_UNKNOWN;
                state <= S_DONE;
              end
            end
          endcase
        end
        S_RD_A: begin
          // zero divisor ends the item with the dividend left in place
          if (op == rpn_pkg::OP_DIV && opb == '0) begin
            status <= first_err(status, rpn_pkg::ST_ZDIV);
            state <= S_DONE;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (wcnt != '0) begin
            opa <= rd_data;
            wcnt <= wcnt - CW'(1);
          end else begin
            opa <= '0;
            status <= first_err(status, rpn_pkg::ST_EMPTY);
          end
          state <= S_MUL;
          step <= '0;
          acc <= '0;
        end
        S_MUL: begin
          // operands settled; start the right engine
          case (op)
            rpn_pkg::OP_ADD: begin
              res1 <= opa + opb;
              npush <= 2'd1;
              state <= S_WR1;
            end
            rpn_pkg::OP_SUB: begin
              res1 <= opa - opb;
              npush <= 2'd1;
              state <= S_WR1;
            end
            rpn_pkg::OP_SWAP: begin
              // b (the old top) was popped first; push it back first so a ends on top
              res1 <= opb;
              res2 <= opa;
              npush <= 2'd2;
              state <= S_WR1;
            end
            rpn_pkg::OP_MUL: begin
              if (step == '0) begin
                acc <= '0;
                mplier <= opb;
                step <= 6'd1;
              end else if (step <= 6'd32) begin
                // one multiplier bit a cycle, msb first; top bit has negative weight
                if (mplier[31]) begin
                  if (step == 6'd1) acc <= (acc <<< 1) - {{32{opa[31]}}, opa};
                  else acc <= (acc <<< 1) + {{32{opa[31]}}, opa};
                end else begin
                  acc <= acc <<< 1;
                end
                mplier <= mplier << 1;
                step <= step + 6'd1;
              end else begin
                res1 <= sat_mul;
                npush <= 2'd1;
                state <= S_WR1;
              end
            end
            default: begin
              // division setup on magnitudes
              neg <= opa[31] ^ opb[31];
              dquo <= {(opa[31] ? -opa : opa), 16'h0000};
              dvs <= opb[31] ? -opb : opb;
              drem <= '0;
              step <= '0;
              state <= S_DIV;
            end
          endcase
        end
        S_DIV: begin
          // one restoring step a cycle
          if (step < 6'd48) begin
            if (!rem_try[32]) begin
              drem <= rem_try;
              dquo <= {dquo[46:0], 1'b1};
            end else begin
              drem <= {drem[31:0], dquo[47]};
              dquo <= {dquo[46:0], 1'b0};
            end
            step <= step + 6'd1;
          end else begin
            res1 <= sat_div;
            npush <= 2'd1;
            state <= S_WR1;
          end
        end
        S_WR1: begin
          if (npush != 2'd0) begin
            if (wcnt < CW'(STACK_DEPTH)) wcnt <= wcnt + CW'(1);
            else status <= first_err(status, rpn_pkg::ST_FULL);
          end
          state <= (npush == 2'd2) ? S_WR2 : S_DONE;
        end
        S_WR2: begin
          if (wcnt < CW'(STACK_DEPTH)) wcnt <= wcnt + CW'(1);
          else status <= first_err(status, rpn_pkg::ST_FULL);
          state <= S_DONE;
        end
        S_DONE: begin
          if (!obusy || out_ready) begin
            out_data.result <= result;
            out_data.has_value <= has;
            out_data.status <= status;
            out_data.depth <= 8'(wcnt);
            cnt <= wcnt;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: verif/tb_rpn_stack_calculator.sv
// tb_rpn_stack_calculator: self-checking bench for the rpn stack calculator
// depends on rpn_pkg and rpn_stack_calculator; predicts each result beat in
// a behavioural stack model and compares in order
`timescale 1ns / 100ps

module tb_rpn_stack_calculator;

  localparam int DEPTH = rpn_pkg::STACK_DEPTH_DEF;

  // operation codes with no meaning
  localparam logic [3:0] OP_UNKNOWN_FIRST = 4'd10;
  localparam logic [3:0] OP_UNKNOWN_LAST  = 4'd15;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  rpn_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  rpn_pkg::out_item_t out_data;

  rpn_stack_calculator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // predicted stack contents
  logic signed [31:0] calc_stack [DEPTH];
  int unsigned        calc_count = 0;
  rpn_pkg::status_t   step_status;

  rpn_pkg::in_item_t  pending_items [$];
  rpn_pkg::out_item_t expected_results [$];
  int        sender_idle_pct = 0;
  int        receiver_idle_pct = 0;
  int        holdoff_cycles = 0;
  int        error_count = 0;

  function automatic void flag_status(rpn_pkg::status_t s);
    if (step_status == rpn_pkg::ST_OK) step_status = s;
  endfunction

  function automatic void stack_push(logic signed [31:0] v);
    if (calc_count < DEPTH) begin
      calc_stack[calc_count] = v;
      calc_count++;
    end else begin
      flag_status(rpn_pkg::ST_FULL);
    end
  endfunction

  function automatic logic signed [31:0] stack_pop(output bit ok);
    if (calc_count > 0) begin
      ok = 1'b1;
      calc_count--;
      return calc_stack[calc_count];
    end
    ok = 1'b0;
    flag_status(rpn_pkg::ST_EMPTY);
    return '0;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // predicted result for one accepted item
  function automatic rpn_pkg::out_item_t calc_step(rpn_pkg::in_item_t it);
    rpn_pkg::out_item_t r;
    logic signed [31:0] a, b;
    logic signed [63:0] p;
    bit                 ok;
    r = '0;
    a = '0;
    b = '0;
    step_status = rpn_pkg::ST_OK;
    case (it.op)
      rpn_pkg::OP_PUSH: stack_push(it.value);
      rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
        b = stack_pop(ok);
        a = stack_pop(ok);
        if (it.op == rpn_pkg::OP_ADD) stack_push(a + b);
        else if (it.op == rpn_pkg::OP_SUB) stack_push(a - b);
        else begin
          // arithmetic shift floors toward minus infinity
          p = (64'(a) * 64'(b)) >>> 16;
          stack_push(clamp32(p));
        end
      end
      rpn_pkg::OP_DIV: begin
        b = stack_pop(ok);
        if (b != 0) begin
          a = stack_pop(ok);
          p = (64'(a) <<< 16) / 64'(b);
          stack_push(clamp32(p));
        end else begin
          flag_status(rpn_pkg::ST_ZDIV);
        end
      end
      rpn_pkg::OP_PEEK: begin
        if (calc_count > 0) begin
          r.result = calc_stack[calc_count - 1];
          r.has_value = 1'b1;
        end else begin
          flag_status(rpn_pkg::ST_EMPTY);
        end
      end
      rpn_pkg::OP_SWAP: begin
        a = stack_pop(ok);
        b = stack_pop(ok);
        stack_push(a);
        stack_push(b);
      end
      rpn_pkg::OP_CLEAR: calc_count = 0;
      rpn_pkg::OP_DUP: begin
        a = stack_pop(ok);
        stack_push(a);
        stack_push(a);
      end
      rpn_pkg::OP_POP: begin
        a = stack_pop(ok);
        if (ok) begin
          r.result = a;
          r.has_value = 1'b1;
        end
      end
      default: flag_status(rpn_pkg::ST_UNKNOWN);
    endcase
    r.status = step_status;
    r.depth = calc_count[7:0];
    return r;
  endfunction

  function automatic rpn_pkg::in_item_t mk(logic [3:0] op, logic signed [31:0] v);
    rpn_pkg::in_item_t it;
    it.op = op;
    it.value = v;
    return it;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 131071)) - 65536);
      2: return 32'sh7fffffff - $urandom_range(0, 3);
      3: return 32'sh80000000 + $urandom_range(0, 3);
      4: return 32'sd0;
      default: return 32'($signed($urandom_range(0, 2047)) - 1024) <<< 16;
    endcase
  endfunction

  // driver: offers beats from the pending queue, front stays until accepted
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) void'(pending_items.pop_front());
      if (pending_items.size() > 0 &&
          $urandom_range(0, 99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_items[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // prediction on every accepted input beat
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      expected_results.push_back(calc_step(in_data));
  end

  // receiver back-pressure, with an optional long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holdoff_cycles > 0) begin
      holdoff_cycles <= holdoff_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // monitor: compare each result beat against the oldest prediction
  always @(posedge clk) begin
    rpn_pkg::out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat, actual %p", $time, out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_data.result !== want.result)
          $display("%0t: result expected %h actual %h", $time, want.result,
                   out_data.result);
        if (out_data.has_value !== want.has_value)
          $display("%0t: has_value expected %b actual %b", $time, want.has_value,
                   out_data.has_value);
        if (out_data.status !== want.status)
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_data.status);
        if (out_data.depth !== want.depth)
          $display("%0t: depth expected %0d actual %0d", $time, want.depth,
                   out_data.depth);
        if (out_data !== want) error_count++;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // directed then random phases
  task automatic add_random(int n);
    int  k;
    logic [3:0] op;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: op = rpn_pkg::OP_PUSH;
        6, 7: op = rpn_pkg::OP_ADD;
        8: op = rpn_pkg::OP_SUB;
        9, 10: op = rpn_pkg::OP_MUL;
        11, 12: op = rpn_pkg::OP_DIV;
        13: op = rpn_pkg::OP_PEEK;
        14: op = rpn_pkg::OP_SWAP;
        15: op = rpn_pkg::OP_DUP;
        16, 17: op = rpn_pkg::OP_POP;
        18: op = ($urandom_range(0, 9) == 0) ? rpn_pkg::OP_CLEAR : rpn_pkg::OP_PUSH;
        default: op = ($urandom_range(0, 3) == 0) ?
                      4'($urandom_range(OP_UNKNOWN_FIRST, OP_UNKNOWN_LAST)) :
                      rpn_pkg::OP_POP;
      endcase
      pending_items.push_back(mk(op, rand_value()));
    end
  endtask

  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-stack errors, extremes, every operation
    pending_items.push_back(mk(rpn_pkg::OP_POP, 32'sd5));
    pending_items.push_back(mk(rpn_pkg::OP_PEEK, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_ADD, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_SWAP, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_DUP, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_DIV, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_CLEAR, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_PUSH, 32'sh7fffffff));
    pending_items.push_back(mk(rpn_pkg::OP_PUSH, 32'sh7fffffff));
    pending_items.push_back(mk(rpn_pkg::OP_MUL, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_PUSH, 32'sh80000000));
    pending_items.push_back(mk(rpn_pkg::OP_MUL, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_PUSH, 32'sh00000001));
    pending_items.push_back(mk(rpn_pkg::OP_DIV, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_PUSH, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_DIV, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_PUSH, -32'sd3));
    pending_items.push_back(mk(rpn_pkg::OP_PUSH, 32'sd1));
    pending_items.push_back(mk(rpn_pkg::OP_MUL, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_SWAP, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_SUB, 32'sd0));
    pending_items.push_back(mk(OP_UNKNOWN_LAST, 32'sd0));
    pending_items.push_back(mk(OP_UNKNOWN_FIRST, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_POP, 32'sd0));
    wait_drained();

    // fill past full, with the receiver held off so the input stalls
    holdoff_cycles <= 400;
    for (i = 0; i < DEPTH + 2; i++)
      pending_items.push_back(mk(rpn_pkg::OP_PUSH, $urandom));
    pending_items.push_back(mk(rpn_pkg::OP_DUP, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_PEEK, 32'sd0));
    pending_items.push_back(mk(rpn_pkg::OP_CLEAR, 32'sd0));
    wait_drained();

    sender_idle_pct = 30;
    receiver_idle_pct = 85;
    add_random(450);
    wait_drained();
    sender_idle_pct = 85;
    receiver_idle_pct = 30;
    add_random(450);
    wait_drained();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    add_random(500);
    wait_drained();
    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(20ns * 2000000);
    $display("status: fail");
    $finish;
  end

endmodule
